// File: src/h2r_pkg.sv
package h2r_pkg;

  localparam int HUE_W  = 10;
  localparam int PCT_W  = 7;
  localparam int REM_W  = 6;
  localparam int WT_W   = 13;
  localparam int NUM_W  = 20;
  localparam int SUM_W  = 28;
  localparam int DIV_SH = 6;
  localparam int X_W    = SUM_W - DIV_SH;
  localparam int K_W    = 22;
  localparam int PROD_W = X_W + K_W;
  localparam int RCP_SH = 35;
  localparam int CH_W   = 8;

  localparam logic [HUE_W-1:0] HUE_MAX    = 10'd359;
  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [REM_W-1:0] SECTOR_DEG = 6'd60;
  localparam logic [WT_W-1:0]  FULL_WT    = 13'd6000;
  localparam logic [SUM_W-1:0] ROUND_BIAS = 28'd300000;
  localparam logic [K_W-1:0]   RECIP_K    = 22'd3665039;
  localparam logic [CH_W-1:0]  ALPHA      = 8'hFF;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } h2r_sec_t;

  typedef struct packed {
    logic c;
    logic d;
    logic e;
  } h2r_adv_t;

endpackage

// File: src/h2r_in_if.sv
interface h2r_in_if;
  import h2r_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

// File: src/h2r_out_if.sv
interface h2r_out_if;
  import h2r_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [31:0]     packed_color;

  modport source (output valid, output red, output green, output blue,
                  output packed_color, input ready);
  modport sink (input valid, input red, input green, input blue,
                input packed_color, output ready);
endinterface

// File: src/hsv_to_rgb_converter_core.sv
// Channel   Dir  Word
// in_chan   in   hue[9:0], saturation[6:0], brightness[6:0]
// out_chan  out  red[7:0], green[7:0], blue[7:0], packed_color[31:0]
//
// One word accepted per cycle while the output is not stalled.
// Stages: clamp and sector split, weight select, v*w, 255x plus rounding bias over
// 64, reciprocal multiply by 1/9375 into the output register.
// rst_n is synchronous and clears the stage valid bits only.
// A stalled output holds every full stage; empty stages still fill.
module hsv_to_rgb_converter_core
  import h2r_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  h2r_in_if.sink         in_chan,
  h2r_out_if.source      out_chan
);

  logic            f_valid, f_ready;
  logic [PCT_W-1:0] f_val;
  logic [WT_W-1:0] f_wr, f_wg, f_wb;
  logic            vld_c_r, vld_d_r, vld_e_r;
  logic            rdy_c, rdy_d, rdy_e;
  h2r_adv_t        adv;
  logic [CH_W-1:0] red, green, blue;

  h2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_hue   (in_chan.hue),
    .in_sat   (in_chan.saturation),
    .in_val   (in_chan.brightness),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_val   (f_val),
    .dn_wr    (f_wr),
    .dn_wg    (f_wg),
    .dn_wb    (f_wb)
  );

  assign rdy_e   = !vld_e_r || out_chan.ready;
  assign rdy_d   = !vld_d_r || rdy_e;
  assign rdy_c   = !vld_c_r || rdy_d;
  assign f_ready = rdy_c;

  assign adv.c = rdy_c && f_valid;
  assign adv.d = rdy_d && vld_c_r;
  assign adv.e = rdy_e && vld_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else begin
      if (rdy_c) begin
        vld_c_r <= f_valid;
      end
      if (rdy_d) begin
        vld_d_r <= vld_c_r;
      end
      if (rdy_e) begin
        vld_e_r <= vld_d_r;
      end
    end
  end

  h2r_scale u_scale_r (
    .clk  (clk),
    .adv  (adv),
    .val  (f_val),
    .wt   (f_wr),
    .chan (red)
  );

  h2r_scale u_scale_g (
    .clk  (clk),
    .adv  (adv),
    .val  (f_val),
    .wt   (f_wg),
    .chan (green)
  );

  h2r_scale u_scale_b (
    .clk  (clk),
    .adv  (adv),
    .val  (f_val),
    .wt   (f_wb),
    .chan (blue)
  );

  assign out_chan.valid        = vld_e_r;
  assign out_chan.red          = red;
  assign out_chan.green        = green;
  assign out_chan.blue         = blue;
  assign out_chan.packed_color = {ALPHA, blue, green, red};

endmodule

// File: src/h2r_front.sv
module h2r_front
  import h2r_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [PCT_W-1:0] in_sat,
  input  logic [PCT_W-1:0] in_val,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [PCT_W-1:0] dn_val,
  output logic [WT_W-1:0]  dn_wr,
  output logic [WT_W-1:0]  dn_wg,
  output logic [WT_W-1:0]  dn_wb
);

  logic             vld_a_r, vld_b_r;
  logic             rdy_a, rdy_b;
  logic [PCT_W-1:0] sat_a_r, val_a_r, val_b_r;
  h2r_sec_t         sec_a_r, sec_nxt;
  logic [REM_W-1:0] rem_a_r, rem_nxt;
  logic [HUE_W-1:0] hue_c;
  logic [HUE_W-1:0] base;
  logic [WT_W-1:0]  wr_b_r, wg_b_r, wb_b_r;
  logic [WT_W-1:0]  wp, wq, wt, wv;
  logic [WT_W-1:0]  sr_q, sr_t;
  logic [REM_W-1:0] rem_inv;

  assign rdy_b    = !vld_b_r || dn_ready;
  assign rdy_a    = !vld_a_r || rdy_b;
  assign in_ready = rdy_a;

  assign hue_c = (in_hue > HUE_MAX) ? HUE_MAX : in_hue;

  always_comb begin
    if (hue_c >= 10'd300) begin
      sec_nxt = SEC_MR;
      base    = 10'd300;
    end else if (hue_c >= 10'd240) begin
      sec_nxt = SEC_BM;
      base    = 10'd240;
    end else if (hue_c >= 10'd180) begin
      sec_nxt = SEC_CB;
      base    = 10'd180;
    end else if (hue_c >= 10'd120) begin
      sec_nxt = SEC_GC;
      base    = 10'd120;
    end else if (hue_c >= 10'd60) begin
      sec_nxt = SEC_YG;
      base    = 10'd60;
    end else begin
      sec_nxt = SEC_RY;
      base    = 10'd0;
    end
  end

  assign rem_nxt = REM_W'(hue_c - base);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (rdy_a) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      sat_a_r <= (in_sat > PCT_MAX) ? PCT_MAX : in_sat;
      val_a_r <= (in_val > PCT_MAX) ? PCT_MAX : in_val;
      sec_a_r <= sec_nxt;
      rem_a_r <= rem_nxt;
    end
  end

  assign rem_inv = SECTOR_DEG - rem_a_r;
  assign sr_q    = WT_W'(sat_a_r) * WT_W'(rem_a_r);
  assign sr_t    = WT_W'(sat_a_r) * WT_W'(rem_inv);
  assign wv      = FULL_WT;
  assign wp      = WT_W'(PCT_MAX - sat_a_r) * WT_W'(SECTOR_DEG);
  assign wq      = FULL_WT - sr_q;
  assign wt      = FULL_WT - sr_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (rdy_b) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && vld_a_r) begin
      val_b_r <= val_a_r;
      case (sec_a_r)
        SEC_RY: begin
          wr_b_r <= wv; wg_b_r <= wt; wb_b_r <= wp;
        end
        SEC_YG: begin
          wr_b_r <= wq; wg_b_r <= wv; wb_b_r <= wp;
        end
        SEC_GC: begin
          wr_b_r <= wp; wg_b_r <= wv; wb_b_r <= wt;
        end
        SEC_CB: begin
          wr_b_r <= wp; wg_b_r <= wq; wb_b_r <= wv;
        end
        SEC_BM: begin
          wr_b_r <= wt; wg_b_r <= wp; wb_b_r <= wv;
        end
        default: begin
          wr_b_r <= wv; wg_b_r <= wp; wb_b_r <= wq;
        end
      endcase
    end
  end

  assign dn_valid = vld_b_r;
  assign dn_val   = val_b_r;
  assign dn_wr    = wr_b_r;
  assign dn_wg    = wg_b_r;
  assign dn_wb    = wb_b_r;

endmodule

// File: src/h2r_scale.sv
module h2r_scale
  import h2r_pkg::*;
(
  input  logic             clk,
  input  h2r_adv_t         adv,
  input  logic [PCT_W-1:0] val,
  input  logic [WT_W-1:0]  wt,
  output logic [CH_W-1:0]  chan
);

  logic [NUM_W-1:0]  num_r;
  logic [X_W-1:0]    x_r;
  logic [CH_W-1:0]   q_r;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign sum  = (SUM_W'(num_r) << 8) - SUM_W'(num_r) + ROUND_BIAS;
  assign prod = PROD_W'(x_r) * PROD_W'(RECIP_K);

  always_ff @(posedge clk) begin
    if (adv.c) begin
      num_r <= NUM_W'(val) * NUM_W'(wt);
    end
    if (adv.d) begin
      x_r <= sum[SUM_W-1:DIV_SH];
    end
    if (adv.e) begin
      q_r <= prod[RCP_SH+CH_W-1:RCP_SH];
    end
  end

  assign chan = q_r;

endmodule
